// ===== rtl/core/dpf_pkg.sv =====
package dpf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_LIT = 2'd0;
  localparam logic [1:0] KIND_HEX = 2'd1;
  localparam logic [1:0] KIND_BIN = 2'd2;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ESC   = 8'h7d;
  localparam logic [7:0] ESC_XOR  = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       packet_first;
    logic       packet_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       packet_end;
  } out_item_t;

  // Classified work for the back end: up to two payload characters plus framing flags
  typedef struct packed {
    logic       first;
    logic       last;
    logic       two_chars;
    logic [7:0] c0;
    logic [7:0] c1;
  } job_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_P0,
    PH_P1,
    PH_HASH,
    PH_HI,
    PH_LO
  } phase_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = 8'h30 + {4'h0, v};
    end else begin
      d = 8'h57 + {4'h0, v};
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/dpf_front.sv =====
module dpf_front (
  input  logic              in_valid,
  input  dpf_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              in_stall,
  output logic              q_push,
  output dpf_pkg::job_t     q_job
);

  logic is_special;

  assign is_special = (in_data.data_byte == dpf_pkg::CH_END)
                   || (in_data.data_byte == dpf_pkg::CH_START)
                   || (in_data.data_byte == dpf_pkg::CH_ESC);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_job.first     = in_data.packet_first;
    q_job.last      = in_data.packet_last;
    q_job.two_chars = 1'b0;
    q_job.c0        = in_data.data_byte;
    q_job.c1        = in_data.data_byte;
    unique case (in_data.kind)
      dpf_pkg::KIND_HEX: begin
        q_job.two_chars = 1'b1;
        q_job.c0        = dpf_pkg::hex_digit(in_data.data_byte[7:4]);
        q_job.c1        = dpf_pkg::hex_digit(in_data.data_byte[3:0]);
      end
      dpf_pkg::KIND_BIN: begin
        if (is_special) begin
          q_job.two_chars = 1'b1;
          q_job.c0        = dpf_pkg::CH_ESC;
          q_job.c1        = in_data.data_byte ^ dpf_pkg::ESC_XOR;
        end
      end
      // literal and the unused code pass the byte through
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/dpf_queue.sv =====
module dpf_queue #(
  parameter int unsigned DEPTH = dpf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dpf_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output dpf_pkg::job_t head_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  dpf_pkg::job_t  slots_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count overflow");

endmodule

// ===== rtl/core/dpf_back.sv =====
module dpf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  dpf_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dpf_pkg::out_item_t out_data
);

  dpf_pkg::phase_t    phase_r, phase_nxt, eff;
  logic [7:0]         sum_r, sum_nxt;
  logic               out_valid_r;
  dpf_pkg::out_item_t out_data_r;
  logic               load;
  logic               done;
  logic [7:0]         ch;

  assign load      = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = load && done;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skip the start marker when the job does not open a packet
  assign eff = (phase_r == dpf_pkg::PH_START && !q_job.first) ? dpf_pkg::PH_P0 : phase_r;

  // next state
  always_comb begin
    phase_nxt = dpf_pkg::PH_START;
    done      = 1'b0;
    unique case (eff)
      dpf_pkg::PH_START: phase_nxt = dpf_pkg::PH_P0;
      dpf_pkg::PH_P0: begin
        if (q_job.two_chars) begin
          phase_nxt = dpf_pkg::PH_P1;
        end else if (q_job.last) begin
          phase_nxt = dpf_pkg::PH_HASH;
        end else begin
          done = 1'b1;
        end
      end
      dpf_pkg::PH_P1: begin
        if (q_job.last) begin
          phase_nxt = dpf_pkg::PH_HASH;
        end else begin
          done = 1'b1;
        end
      end
      dpf_pkg::PH_HASH: phase_nxt = dpf_pkg::PH_HI;
      dpf_pkg::PH_HI:   phase_nxt = dpf_pkg::PH_LO;
      dpf_pkg::PH_LO:   done = 1'b1;
      default:          done = 1'b1;
    endcase
  end

  // outputs and checksum
  always_comb begin
    ch      = q_job.c0;
    sum_nxt = sum_r;
    unique case (eff)
      dpf_pkg::PH_START: begin
        ch      = dpf_pkg::CH_START;
        sum_nxt = '0;
      end
      dpf_pkg::PH_P0: begin
        ch      = q_job.c0;
        sum_nxt = sum_r + q_job.c0;
      end
      dpf_pkg::PH_P1: begin
        ch      = q_job.c1;
        sum_nxt = sum_r + q_job.c1;
      end
      dpf_pkg::PH_HASH: ch = dpf_pkg::CH_END;
      dpf_pkg::PH_HI:   ch = dpf_pkg::hex_digit(sum_r[7:4]);
      dpf_pkg::PH_LO: begin
        ch      = dpf_pkg::hex_digit(sum_r[3:0]);
        sum_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dpf_pkg::PH_START;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_char   <= ch;
      out_data_r.run_last   <= done;
      out_data_r.packet_end <= (eff == dpf_pkg::PH_LO);
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.packet_end |-> out_data_r.run_last)
    else $error("packet end without run end");

  a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != dpf_pkg::PH_START |-> q_valid)
    else $error("job head lost mid sequence");

  a_hash_then_hi: assert property (@(posedge clk) disable iff (!rst_n)
    load && eff == dpf_pkg::PH_HASH |=> phase_r == dpf_pkg::PH_HI)
    else $error("checksum digits do not follow end marker");

endmodule

// ===== rtl/core/debug_packet_framer.sv =====
// Debug packet framer: takes one payload byte per beat and emits the framed
// character stream ('$', payload characters, '#', two checksum hex digits),
// one character per beat on the out channel. A front end classifies each
// beat into one or two payload characters and queues it; the back end
// sequencer emits one character per cycle while an item is queued and the out
// channel does not stall, so an item yields 1 to 6 characters (its first
// payload character plus start marker, second hex or escape character and
// three trailer characters, as they apply). The output register lets the
// back end load a new character in the same cycle the previous one is taken,
// and the QDEPTH-item queue keeps the input taking beats during a long item.
module debug_packet_framer #(
  parameter int unsigned QDEPTH = dpf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dpf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dpf_pkg::out_item_t out_data
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_valid;
  dpf_pkg::job_t push_job;
  dpf_pkg::job_t head_job;

  dpf_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  dpf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  dpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
